// ----- src/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants of the pointer motion smoother.
// ----------------------------------------------------------------------------
package pms_pkg;

   localparam int DELTA_W     = 12;
   localparam int SENS_W      = 16;
   localparam int LEN_W       = 4;
   localparam int EXTENT_W    = 13;
   localparam int SCALED_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = DELTA_W + SENS_W + 1;
   localparam int Q_FRAC_W    = 8;

   localparam logic [SENS_W-1:0]   SENS_RESET   = 16'd256;
   localparam logic                SMOOTH_RESET = 1'b1;
   localparam logic [LEN_W-1:0]    LEN_RESET    = 4'd3;
   localparam logic [EXTENT_W-1:0] WIDTH_RESET  = 13'd800;
   localparam logic [EXTENT_W-1:0] HEIGHT_RESET = 13'd600;
   localparam int                  CURSOR_X_RESET = 400;
   localparam int                  CURSOR_Y_RESET = 300;

   typedef enum logic [1:0] {
      OP_MOTION  = 2'd0,
      OP_ENABLE  = 2'd1,
      OP_DISABLE = 2'd2,
      OP_UNUSED  = 2'd3
   } pms_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENSITIVITY   = 3'd0,
      CSR_SMOOTHING     = 3'd1,
      CSR_WINDOW_LENGTH = 3'd2,
      CSR_SCREEN_WIDTH  = 3'd3,
      CSR_SCREEN_HEIGHT = 3'd4
   } pms_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCALE,
      ST_SATURATE,
      ST_WRITE,
      ST_SUM,
      ST_DIV_START,
      ST_DIV,
      ST_CLAMP,
      ST_FINISH
   } pms_state_type;

   typedef struct packed {
      logic load;
      logic recenter;
      logic deactivate;
      logic scale;
      logic saturate;
      logic win_clear;
      logic win_write;
      logic acc_step;
      logic div_start;
      logic div_take;
      logic clamp;
      logic result_load;
   } pms_cmd_type;

   typedef struct packed {
      pms_op_type op;
      logic       active;
      logic       smoothing;
      logic       acc_done;
      logic       div_done;
   } pms_status_type;

endpackage

// ----- src/pms_req_if.sv -----
// ----------------------------------------------------------------------------
// pms_req_if
// Request channel: command and raw motion deltas.
// ----------------------------------------------------------------------------
interface pms_req_if;
   import pms_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 command;
   logic signed [DELTA_W-1:0]  delta_x;
   logic signed [DELTA_W-1:0]  delta_y;

   modport source (output valid, command, delta_x, delta_y, input ready);
   modport sink (input valid, command, delta_x, delta_y, output ready);
endinterface

// ----- src/pms_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pms_rsp_if
// Response channel: cursor position and status flags.
// ----------------------------------------------------------------------------
interface pms_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic                  active;
   logic                  moved;

   modport source (output valid, cursor_x, cursor_y, active, moved, input ready);
   modport sink (input valid, cursor_x, cursor_y, active, moved, output ready);
endinterface

// ----- src/pms_ram.sv -----
// ----------------------------------------------------------------------------
// pms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pms_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/pms_divider.sv -----
// ----------------------------------------------------------------------------
// pms_divider
// Two-lane restoring divider, one quotient bit per cycle, truncating
// toward zero on signed numerators.
// ----------------------------------------------------------------------------
module pms_divider #(
   parameter int SUM_W = 19,
   parameter int DEN_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] numer_x,
   input  logic signed [SUM_W-1:0] numer_y,
   input  logic [DEN_W-1:0]        denom,
   output logic signed [SUM_W-1:0] quot_x,
   output logic signed [SUM_W-1:0] quot_y,
   output logic                    done
);
   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic [SUM_W-1:0] dvd_ff [2];
   logic [DEN_W-1:0] rem_ff [2];
   logic             neg_ff [2];

   logic [SUM_W-1:0] numer [2];
   logic [DEN_W:0]   rem_sh [2];
   logic [DEN_W:0]   diff [2];
   logic             take [2];
   logic [SUM_W-1:0] dvd_in [2];
   logic [DEN_W-1:0] rem_in [2];

   assign numer[0] = numer_x;
   assign numer[1] = numer_y;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rem_sh[i] = {rem_ff[i], dvd_ff[i][SUM_W-1]};
         diff[i]   = rem_sh[i] - {1'b0, den_ff};
         take[i]   = (rem_sh[i] >= {1'b0, den_ff});
         rem_in[i] = take[i] ? diff[i][DEN_W-1:0] : rem_sh[i][DEN_W-1:0];
         dvd_in[i] = {dvd_ff[i][SUM_W-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(SUM_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= denom;
         for (int i = 0; i < 2; i++) begin
            neg_ff[i] <= numer[i][SUM_W-1];
            dvd_ff[i] <= numer[i][SUM_W-1] ? (~numer[i] + 1'b1) : numer[i];
            rem_ff[i] <= '0;
         end
      end else if (cnt_ff != '0) begin
         for (int i = 0; i < 2; i++) begin
            dvd_ff[i] <= dvd_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   assign quot_x = neg_ff[0] ? -$signed(dvd_ff[0]) : $signed(dvd_ff[0]);
   assign quot_y = neg_ff[1] ? -$signed(dvd_ff[1]) : $signed(dvd_ff[1]);
   assign done   = (cnt_ff == '0);
endmodule

// ----- src/pms_datapath.sv -----
// ----------------------------------------------------------------------------
// pms_datapath
// Configuration registers, cursor state, delta scaling, window store and
// accumulation, averaging divider, clamp and response register.
// ----------------------------------------------------------------------------
module pms_datapath #(
   parameter int MAX_WINDOW = 8,
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [pms_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pms_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [1:0]                            req_command,
   input  logic signed [pms_pkg::DELTA_W-1:0]    req_delta_x,
   input  logic signed [pms_pkg::DELTA_W-1:0]    req_delta_y,
   output logic [COORD_BITS-1:0]                 rsp_cursor_x,
   output logic [COORD_BITS-1:0]                 rsp_cursor_y,
   output logic                                  rsp_active,
   output logic                                  rsp_moved,
   input  pms_pkg::pms_cmd_type                  cmd,
   output pms_pkg::pms_status_type               status
);
   import pms_pkg::*;

   localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int LCMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int SUM_W      = SCALED_W + $clog2(MAX_WINDOW);
   localparam int V_W        = ((COORD_BITS > SCALED_W) ? COORD_BITS : SCALED_W) + 2;
   localparam int E_W        = ((COORD_BITS + 1) > EXTENT_W) ? (COORD_BITS + 1) : EXTENT_W;
   localparam int COORD_SPAN = 1 << COORD_BITS;
   localparam int COORD_MAX  = COORD_SPAN - 1;
   localparam int SAT_MAX    = (1 << (SCALED_W - 1)) - 1;
   localparam int SAT_MIN    = -(1 << (SCALED_W - 1));
   localparam int Q_W        = PROD_W - Q_FRAC_W;

   function automatic logic signed [SCALED_W-1:0] scale_sat(
      input logic signed [PROD_W-1:0] p
   );
      logic [PROD_W-1:0]     biased;
      logic signed [Q_W-1:0] q;
      logic signed [SCALED_W-1:0] r;
      biased = p + (p[PROD_W-1] ? PROD_W'((1 << Q_FRAC_W) - 1) : PROD_W'(0));
      q      = $signed(biased[PROD_W-1:Q_FRAC_W]);
      if (q > SAT_MAX) begin
         r = SCALED_W'(SAT_MAX);
      end else if (q < SAT_MIN) begin
         r = SCALED_W'(SAT_MIN);
      end else begin
         r = q[SCALED_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [E_W-1:0] axis_limit(input logic [EXTENT_W-1:0] ext);
      logic [E_W-1:0] e;
      logic [E_W-1:0] r;
      e = E_W'(ext);
      if (e == '0) begin
         r = '0;
      end else if (e > E_W'(COORD_SPAN)) begin
         r = E_W'(COORD_MAX);
      end else begin
         r = e - 1'b1;
      end
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] half_axis(input logic [EXTENT_W-1:0] ext);
      logic [E_W-1:0] h;
      logic [COORD_BITS-1:0] r;
      h = E_W'(ext >> 1);
      if (h > E_W'(COORD_MAX)) begin
         r = COORD_BITS'(COORD_MAX);
      end else begin
         r = h[COORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_axis(
      input logic [COORD_BITS-1:0]      pos,
      input logic signed [SCALED_W-1:0] d,
      input logic [EXTENT_W-1:0]        ext
   );
      logic [E_W-1:0]        hi;
      logic signed [V_W-1:0] v;
      logic [COORD_BITS-1:0] r;
      hi = axis_limit(ext);
      v  = $signed(V_W'(pos)) + V_W'(d);
      if (v[V_W-1]) begin
         r = '0;
      end else if ($unsigned(v) > V_W'(hi)) begin
         r = hi[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // configuration
   logic [SENS_W-1:0]   sens_ff;
   logic                smooth_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [EXTENT_W-1:0] width_ff;
   logic [EXTENT_W-1:0] height_ff;

   // block state
   logic [COORD_BITS-1:0] cursor_x_ff;
   logic [COORD_BITS-1:0] cursor_y_ff;
   logic                  active_ff;
   logic                  moved_ff;
   logic [IDX_W-1:0]      head_ff;
   logic [CNT_W-1:0]      fill_ff;
   logic [IDX_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      issue_cnt_ff;
   logic                  rd_valid_ff;

   // item payload
   pms_op_type                 op_ff;
   logic signed [DELTA_W-1:0]  dx_ff;
   logic signed [DELTA_W-1:0]  dy_ff;
   logic signed [PROD_W-1:0]   prod_x_ff;
   logic signed [PROD_W-1:0]   prod_y_ff;
   logic signed [SCALED_W-1:0] avg_x_ff;
   logic signed [SCALED_W-1:0] avg_y_ff;
   logic signed [SUM_W-1:0]    sum_x_ff;
   logic signed [SUM_W-1:0]    sum_y_ff;
   logic [COORD_BITS-1:0]      rsp_x_ff;
   logic [COORD_BITS-1:0]      rsp_y_ff;
   logic                       rsp_active_ff;
   logic                       rsp_moved_ff;

   logic signed [PROD_W-1:0]   prod_x_in;
   logic signed [PROD_W-1:0]   prod_y_in;
   logic [LCMP_W-1:0]          len_wide;
   logic [CNT_W-1:0]           eff_len;
   logic [CNT_W:0]             fill_inc;
   logic [CNT_W-1:0]           fill_in;
   logic [IDX_W-1:0]           head_in;
   logic [IDX_W-1:0]           rd_ptr_in;
   logic                       rd_en;
   logic [2*SCALED_W-1:0]      rd_data;
   logic signed [SUM_W-1:0]    quot_x;
   logic signed [SUM_W-1:0]    quot_y;
   logic                       div_done;
   logic                       csr_clear;

   assign prod_x_in = dx_ff * $signed({1'b0, sens_ff});
   assign prod_y_in = dy_ff * $signed({1'b0, sens_ff});

   always_comb begin
      len_wide = LCMP_W'(len_ff);
      if (len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (len_wide > LCMP_W'(MAX_WINDOW)) begin
         eff_len = CNT_W'(MAX_WINDOW);
      end else begin
         eff_len = len_wide[CNT_W-1:0];
      end
      fill_inc = {1'b0, fill_ff} + 1'b1;
      if (fill_inc > {1'b0, eff_len}) begin
         fill_in = eff_len;
      end else begin
         fill_in = fill_inc[CNT_W-1:0];
      end
      head_in   = (head_ff == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == '0) ? IDX_W'(MAX_WINDOW - 1) : rd_ptr_ff - 1'b1;
   end

   assign rd_en     = cmd.acc_step && (issue_cnt_ff != fill_ff);
   assign csr_clear = csr_we && (csr_index == CSR_SMOOTHING) && !csr_wdata[0];

   pms_ram #(
      .WIDTH (2 * SCALED_W),
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.win_write),
      .wr_addr (head_ff),
      .wr_data ({avg_x_ff, avg_y_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   pms_divider #(
      .SUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .numer_x (sum_x_ff),
      .numer_y (sum_y_ff),
      .denom   (fill_ff),
      .quot_x  (quot_x),
      .quot_y  (quot_y),
      .done    (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff      <= SENS_RESET;
         smooth_ff    <= SMOOTH_RESET;
         len_ff       <= LEN_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         cursor_x_ff  <= COORD_BITS'(CURSOR_X_RESET);
         cursor_y_ff  <= COORD_BITS'(CURSOR_Y_RESET);
         active_ff    <= 1'b0;
         moved_ff     <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rd_ptr_ff    <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SENSITIVITY:   sens_ff   <= csr_wdata[SENS_W-1:0];
               CSR_SMOOTHING:     smooth_ff <= csr_wdata[0];
               CSR_WINDOW_LENGTH: len_ff    <= csr_wdata[LEN_W-1:0];
               CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[EXTENT_W-1:0];
               CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[EXTENT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            moved_ff <= 1'b0;
         end
         if (cmd.recenter) begin
            active_ff   <= 1'b1;
            cursor_x_ff <= half_axis(width_ff);
            cursor_y_ff <= half_axis(height_ff);
         end
         if (cmd.deactivate) begin
            active_ff <= 1'b0;
         end
         if (cmd.win_clear || csr_clear) begin
            head_ff <= '0;
            fill_ff <= '0;
         end
         if (cmd.win_write) begin
            head_ff      <= head_in;
            fill_ff      <= fill_in;
            rd_ptr_ff    <= head_ff;
            issue_cnt_ff <= '0;
         end
         if (rd_en) begin
            rd_ptr_ff    <= rd_ptr_in;
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
         end
         rd_valid_ff <= rd_en;
         if (cmd.clamp) begin
            cursor_x_ff <= clamp_axis(cursor_x_ff, avg_x_ff, width_ff);
            cursor_y_ff <= clamp_axis(cursor_y_ff, avg_y_ff, height_ff);
            moved_ff    <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= pms_op_type'(req_command);
         dx_ff <= req_delta_x;
         dy_ff <= req_delta_y;
      end
      if (cmd.scale) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
      if (cmd.saturate) begin
         avg_x_ff <= scale_sat(prod_x_ff);
         avg_y_ff <= scale_sat(prod_y_ff);
      end else if (cmd.div_take) begin
         avg_x_ff <= quot_x[SCALED_W-1:0];
         avg_y_ff <= quot_y[SCALED_W-1:0];
      end
      if (cmd.win_write) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else if (rd_valid_ff) begin
         sum_x_ff <= sum_x_ff + SUM_W'($signed(rd_data[2*SCALED_W-1:SCALED_W]));
         sum_y_ff <= sum_y_ff + SUM_W'($signed(rd_data[SCALED_W-1:0]));
      end
      if (cmd.result_load) begin
         rsp_x_ff      <= cursor_x_ff;
         rsp_y_ff      <= cursor_y_ff;
         rsp_active_ff <= active_ff;
         rsp_moved_ff  <= moved_ff;
      end
   end

   assign status.op        = op_ff;
   assign status.active    = active_ff;
   assign status.smoothing = smooth_ff;
   assign status.acc_done  = (issue_cnt_ff == fill_ff) && !rd_valid_ff;
   assign status.div_done  = div_done;

   assign rsp_cursor_x = rsp_x_ff;
   assign rsp_cursor_y = rsp_y_ff;
   assign rsp_active   = rsp_active_ff;
   assign rsp_moved    = rsp_moved_ff;
endmodule

// ----- src/pms_ctrl.sv -----
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer for one item at a time and the response valid register.
// ----------------------------------------------------------------------------
module pms_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pms_pkg::pms_cmd_type    cmd,
   input  pms_pkg::pms_status_type status
);
   import pms_pkg::*;

   pms_state_type state_ff;
   pms_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_MOTION: state_in = status.active ? ST_SCALE : ST_FINISH;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_SCALE:     state_in = ST_SATURATE;
         ST_SATURATE:  state_in = status.smoothing ? ST_WRITE : ST_CLAMP;
         ST_WRITE:     state_in = ST_SUM;
         ST_SUM: begin
            if (status.acc_done) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP:     state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         ST_DECODE: begin
            cmd.recenter   = (status.op == OP_ENABLE);
            cmd.deactivate = (status.op == OP_DISABLE);
         end
         ST_SCALE:     cmd.scale = 1'b1;
         ST_SATURATE: begin
            cmd.saturate  = 1'b1;
            cmd.win_clear = !status.smoothing;
         end
         ST_WRITE:     cmd.win_write = 1'b1;
         ST_SUM:       cmd.acc_step = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_DIV:       cmd.div_take = status.div_done;
         ST_CLAMP:     cmd.clamp = 1'b1;
         ST_FINISH:    cmd.result_load = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- src/pointer_motion_smoother.sv -----
// ----------------------------------------------------------------------------
// pointer_motion_smoother
// Scales pointer deltas by a Q8.8 gain, optionally averages over a ring window,
// moves and clamps the cursor; enable recentres, disable stops tracking.
// ----------------------------------------------------------------------------
//   channel   direction  contents
//   req_bus   in         command, delta_x, delta_y
//   rsp_bus   out        cursor_x, cursor_y, active, moved
//   csr_*     in         write enable, register index, write data
//
// one item at a time: enable, disable, unused or ignored motion only decode
// and finish; motion without smoothing adds scale, saturate and clamp;
// smoothed motion also writes and sums the window, starts the divider and
// runs the SUM_W = 16 + clog2(MAX_WINDOW) steps of this shared bit-serial
// divider. the next item is taken while a response waits; a stalled response
// holds the sequencer in its last state. reset is synchronous, needs no sweep.
// ----------------------------------------------------------------------------
module pointer_motion_smoother #(
   parameter int MAX_WINDOW = 8,
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   pms_req_if.sink                           req_bus,
   pms_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [pms_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pms_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pms_pkg::*;

   pms_cmd_type    cmd;
   pms_status_type status;

   pms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pms_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_command  (req_bus.command),
      .req_delta_x  (req_bus.delta_x),
      .req_delta_y  (req_bus.delta_y),
      .rsp_cursor_x (rsp_bus.cursor_x),
      .rsp_cursor_y (rsp_bus.cursor_y),
      .rsp_active   (rsp_bus.active),
      .rsp_moved    (rsp_bus.moved),
      .cmd          (cmd),
      .status       (status)
   );
endmodule

// ----- bench/tb_pointer_motion_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pointer_motion_smoother
// Self-checking bench for the pointer motion smoother. A short stimulus list
// covers reset values, field extremes, every command, register extremes and
// window corner cases. It is followed by random segments, each starting from
// a fresh register setting. Every report is compared field by field against
// a known value from the list or an in-bench tracker of cursor, window and
// gain, under varying valid/ready idling and two long sink hold-offs.
// ----------------------------------------------------------------------------
module tb_pointer_motion_smoother;
   import pms_pkg::*;

   localparam int MAX_WIN         = 8;
   localparam int COORD_MAX       = 4095;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 2000;
   localparam int SEGMENTS        = 10;
   localparam int SEGMENT_ITEMS   = 36;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic        active;
      logic        moved;
   } cursor_report_t;

   typedef struct packed {
      logic               reg_write;
      pms_csr_type        reg_index;
      logic [15:0]        reg_value;
      pms_op_type         op;
      logic signed [11:0] dx;
      logic signed [11:0] dy;
      logic               typed;
      cursor_report_t     report;
   } stimulus_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pms_req_if req_bus ();
   pms_rsp_if #(.COORD_BITS(12)) rsp_bus ();

   pointer_motion_smoother dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // tracker state
   logic [15:0] gain_q8_8;
   logic        smoothing_en;
   logic [3:0]  window_len;
   logic [12:0] extent_x;
   logic [12:0] extent_y;
   int          track_x;
   int          track_y;
   logic        tracking;
   int          win_dx [MAX_WIN];
   int          win_dy [MAX_WIN];
   int          win_head;
   int          win_fill;

   cursor_report_t expected_reports [$];
   stimulus_row_t  directed_rows [$];

   int   src_idle_pct;
   int   sink_idle_pct;
   logic hold_request;
   int   mismatches;
   int   reports_checked;
   int   items_directed;
   int   items_random;
   int   reg_writes;

   function automatic int gain_delta(logic signed [11:0] d);
      int p;
      int q;
      p = d * int'(gain_q8_8);
      q = p / 256;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic int clamp_coord(int pos, int d, logic [12:0] ext);
      int hi;
      int v;
      hi = ext;
      if (hi < 1) hi = 1;
      if (hi > COORD_MAX + 1) hi = COORD_MAX + 1;
      hi = hi - 1;
      v = pos + d;
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int half_extent(logic [12:0] ext);
      int h;
      h = (ext == 0) ? 0 : ext / 2;
      return (h > COORD_MAX) ? COORD_MAX : h;
   endfunction

   function automatic cursor_report_t track_item(pms_op_type op, logic signed [11:0] dx,
                                                 logic signed [11:0] dy);
      cursor_report_t rep;
      int sx;
      int sy;
      int len;
      int slot;
      int total_x;
      int total_y;
      rep.moved = 1'b0;
      if (op == OP_ENABLE) begin
         tracking = 1'b1;
         track_x = half_extent(extent_x);
         track_y = half_extent(extent_y);
      end else if (op == OP_DISABLE) begin
         tracking = 1'b0;
      end else if (op == OP_MOTION && tracking) begin
         sx = gain_delta(dx);
         sy = gain_delta(dy);
         if (smoothing_en) begin
            len = window_len;
            if (len < 1) len = 1;
            if (len > MAX_WIN) len = MAX_WIN;
            slot = win_head;
            win_dx[slot] = sx;
            win_dy[slot] = sy;
            win_head = (slot + 1) % MAX_WIN;
            win_fill = (win_fill + 1 > len) ? len : win_fill + 1;
            total_x = 0;
            total_y = 0;
            for (int i = 0; i < win_fill; i++) begin
               total_x += win_dx[(slot + MAX_WIN - i) % MAX_WIN];
               total_y += win_dy[(slot + MAX_WIN - i) % MAX_WIN];
            end
            sx = total_x / win_fill;
            sy = total_y / win_fill;
         end else begin
            win_head = 0;
            win_fill = 0;
         end
         track_x = clamp_coord(track_x, sx, extent_x);
         track_y = clamp_coord(track_y, sy, extent_y);
         rep.moved = 1'b1;
      end
      rep.x = track_x[11:0];
      rep.y = track_y[11:0];
      rep.active = tracking;
      return rep;
   endfunction

   function automatic stimulus_row_t reg_row(pms_csr_type idx, logic [15:0] val);
      stimulus_row_t r;
      r = '0;
      r.reg_write = 1'b1;
      r.reg_index = idx;
      r.reg_value = val;
      return r;
   endfunction

   function automatic stimulus_row_t item_row(pms_op_type op, int dx, int dy);
      stimulus_row_t r;
      r = '0;
      r.op = op;
      r.dx = dx[11:0];
      r.dy = dy[11:0];
      return r;
   endfunction

   function automatic stimulus_row_t known_row(pms_op_type op, int dx, int dy, int x, int y,
                                               logic act, logic mv);
      stimulus_row_t r;
      r = item_row(op, dx, dy);
      r.typed = 1'b1;
      r.report.x = x[11:0];
      r.report.y = y[11:0];
      r.report.active = act;
      r.report.moved = mv;
      return r;
   endfunction

   function automatic logic signed [11:0] random_delta();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: v = int'($urandom_range(32)) - 16;
         5, 6, 7:       v = int'($urandom_range(511)) - 256;
         default:       v = $urandom;
      endcase
      return v[11:0];
   endfunction

   function automatic logic [15:0] random_extent();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'd4096;
         3:       return 16'd8191;
         default: return 16'($urandom_range(1500, 8));
      endcase
   endfunction

   task automatic write_reg(pms_csr_type idx, logic [15:0] val);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_SENSITIVITY:   gain_q8_8 = val;
         CSR_SMOOTHING: begin
            smoothing_en = val[0];
            if (!val[0]) begin
               win_head = 0;
               win_fill = 0;
            end
         end
         CSR_WINDOW_LENGTH: window_len = val[3:0];
         CSR_SCREEN_WIDTH:  extent_x = val[12:0];
         CSR_SCREEN_HEIGHT: extent_y = val[12:0];
         default: ;
      endcase
   endtask

   task automatic send_item(pms_op_type op, logic signed [11:0] dx, logic signed [11:0] dy,
                            logic typed, cursor_report_t known);
      cursor_report_t predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= op;
      req_bus.delta_x <= dx;
      req_bus.delta_y <= dy;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = track_item(op, dx, dy);
      expected_reports.push_back(typed ? known : predicted);
   endtask

   task automatic compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // sink side: ready, hold-off and report checking
   initial begin
      cursor_report_t want;
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected report x=%0d y=%0d active=%b moved=%b", $time,
                        rsp_bus.cursor_x, rsp_bus.cursor_y, rsp_bus.active, rsp_bus.moved);
            end else begin
               want = expected_reports.pop_front();
               reports_checked++;
               compare_field("cursor_x", want.x, rsp_bus.cursor_x);
               compare_field("cursor_y", want.y, rsp_bus.cursor_y);
               compare_field("active", 12'(want.active), 12'(rsp_bus.active));
               compare_field("moved", 12'(want.moved), 12'(rsp_bus.moved));
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transfer for %0d cycles, %0d reports outstanding", $time, quiet,
               expected_reports.size());
      $display("tb_pointer_motion_smoother: errors");
      $finish;
   end

   initial begin
      pms_op_type         op;
      logic signed [11:0] dx;
      logic signed [11:0] dy;
      logic [15:0]        reg_val;
      int                 roll;
      int                 counted;
      logic               counts;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.command <= OP_MOTION;
      req_bus.delta_x <= '0;
      req_bus.delta_y <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_SENSITIVITY;
      csr_wdata       <= '0;
      hold_request    = 1'b0;
      src_idle_pct    = 32;
      sink_idle_pct   = 46;
      mismatches      = 0;
      reports_checked = 0;
      items_directed  = 0;
      items_random    = 0;
      reg_writes      = 0;

      gain_q8_8    = SENS_RESET;
      smoothing_en = SMOOTH_RESET;
      window_len   = LEN_RESET;
      extent_x     = WIDTH_RESET;
      extent_y     = HEIGHT_RESET;
      track_x      = CURSOR_X_RESET;
      track_y      = CURSOR_Y_RESET;
      tracking     = 1'b0;
      win_head     = 0;
      win_fill     = 0;

      directed_rows = '{
         known_row(OP_MOTION, 5, -5, 400, 300, 1'b0, 1'b0),
         known_row(OP_UNUSED, -2048, 2047, 400, 300, 1'b0, 1'b0),
         known_row(OP_DISABLE, 0, 0, 400, 300, 1'b0, 1'b0),
         known_row(OP_ENABLE, 0, 0, 400, 300, 1'b1, 1'b0),
         known_row(OP_MOTION, 2047, 2047, 799, 599, 1'b1, 1'b1),
         item_row(OP_MOTION, -2048, -2048),
         item_row(OP_MOTION, -2048, -2048),
         known_row(OP_MOTION, -2048, -2048, 0, 0, 1'b1, 1'b1),
         known_row(OP_UNUSED, 0, 0, 0, 0, 1'b1, 1'b0),
         reg_row(CSR_SENSITIVITY, 16'hFFFF),
         item_row(OP_MOTION, 2047, -2048),
         reg_row(CSR_SMOOTHING, 16'd0),
         item_row(OP_MOTION, -1, 1),
         reg_row(CSR_SENSITIVITY, 16'd0),
         item_row(OP_MOTION, 2047, -2048),
         reg_row(CSR_SCREEN_WIDTH, 16'd0),
         reg_row(CSR_SCREEN_HEIGHT, 16'd0),
         known_row(OP_ENABLE, 0, 0, 0, 0, 1'b1, 1'b0),
         reg_row(CSR_SENSITIVITY, 16'd256),
         known_row(OP_MOTION, 100, -100, 0, 0, 1'b1, 1'b1),
         reg_row(CSR_SCREEN_WIDTH, 16'd8191),
         reg_row(CSR_SCREEN_HEIGHT, 16'd4096),
         known_row(OP_ENABLE, 0, 0, 4095, 2048, 1'b1, 1'b0),
         known_row(OP_MOTION, 2047, 2047, 4095, 4095, 1'b1, 1'b1),
         reg_row(CSR_SMOOTHING, 16'd1),
         reg_row(CSR_WINDOW_LENGTH, 16'd0),
         item_row(OP_MOTION, -3, -5),
         reg_row(CSR_WINDOW_LENGTH, 16'd15),
         item_row(OP_MOTION, -1000, 1000),
         item_row(OP_MOTION, 7, -9),
         reg_row(CSR_WINDOW_LENGTH, 16'd2),
         item_row(OP_MOTION, -1, -1),
         reg_row(CSR_SCREEN_WIDTH, 16'd100),
         reg_row(CSR_SCREEN_HEIGHT, 16'd50),
         item_row(OP_UNUSED, 1365, -1366),
         item_row(OP_MOTION, 0, 0),
         item_row(OP_DISABLE, 0, 0),
         item_row(OP_MOTION, 1, 1)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].reg_write) begin
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_item(directed_rows[i].op, directed_rows[i].dx, directed_rows[i].dy,
                      directed_rows[i].typed, directed_rows[i].report);
            items_directed++;
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 4) begin
            src_idle_pct  = 32;
            sink_idle_pct = 46;
         end else if (seg < 7) begin
            src_idle_pct  = 46;
            sink_idle_pct = 32;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end

         case ($urandom_range(5))
            0:       reg_val = 16'd256;
            1:       reg_val = 16'd0;
            2:       reg_val = 16'hFFFF;
            3:       reg_val = 16'($urandom);
            default: reg_val = 16'($urandom_range(1024, 32));
         endcase
         write_reg(CSR_SENSITIVITY, reg_val);
         write_reg(CSR_SMOOTHING, 16'($urandom_range(3) != 0));
         reg_val = ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom_range(8, 1));
         write_reg(CSR_WINDOW_LENGTH, reg_val);
         write_reg(CSR_SCREEN_WIDTH, random_extent());
         write_reg(CSR_SCREEN_HEIGHT, random_extent());

         // long sink stall so the block fills and pushes back on the source
         if (seg == 4 || seg == 8)
            hold_request = 1'b1;

         send_item(OP_ENABLE, random_delta(), random_delta(), 1'b0, '0);
         items_random++;
         counted = 0;
         while (counted < SEGMENT_ITEMS) begin
            roll = $urandom_range(99);
            if (!tracking && roll < 70)
               op = OP_ENABLE;
            else if (roll < 4)
               op = OP_ENABLE;
            else if (roll < 7)
               op = OP_DISABLE;
            else if (roll < 10)
               op = OP_UNUSED;
            else
               op = OP_MOTION;
            dx = random_delta();
            dy = random_delta();
            counts = !(op == OP_UNUSED || (op == OP_MOTION && !tracking));
            send_item(op, dx, dy, 1'b0, '0);
            items_random++;
            if (counts)
               counted++;
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d directed and %0d random items, %0d reports checked",
               items_directed, items_random, reports_checked);
      $display("%0d register writes across %0d settings, idling both ways and two sink stalls",
               reg_writes, SEGMENTS + 1);
      if (mismatches == 0) begin
         $display("tb_pointer_motion_smoother: clean");
      end else begin
         $display("tb_pointer_motion_smoother: errors");
      end
      $finish;
   end

endmodule
